[src/knn_pkg.sv]
// Shared types and constants for the k-nearest-neighbors search block.
// Depends on nothing; every other source file refers to it by scoped names.
package knn_pkg;

    localparam int NEIGHBORS = 16;
    localparam int FEATURES  = 64;

    localparam int FUNC_W  = 2;
    localparam int POS_W   = 10;
    localparam int VAL_W   = 16;
    localparam int SIDX_W  = 16;
    localparam int DIST_W  = 42;
    localparam int RANK_W  = 6;
    localparam int ABS_W   = 16;
    localparam int SQ_W    = 2 * ABS_W;

    localparam int QADDR_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int SLOT_W  = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [POS_W:0]    FEAT_CNT = (POS_W + 1)'(FEATURES);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NEIGHBORS - 1);

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TRAIN = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    typedef struct packed {
        logic [SIDX_W-1:0] idx;
        logic [DIST_W-1:0] dist_sq;
    } t_slot;

    typedef struct packed {
        logic              valid;
        logic [SIDX_W-1:0] idx;
        logic [DIST_W-1:0] dist_sq;
    } t_cand;

endpackage

[src/knn_top_k_search.sv]
// Top level of the k-nearest-neighbors search: distance pipeline, cell chain, readout.
// A finished vector passes distance stages A to D before it reaches the first list cell.
// Throughput: one query or training feature per cycle; a readout holds off input while the
// chain drains, then sends one slot per cycle while the receiver is ready (NEIGHBORS total).
// Reset (synchronous, active low) empties the list, clears the sum and sets the limit to max.
// Depends on knn_pkg, knn_dist and knn_cell.
module knn_top_k_search (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [knn_pkg::FUNC_W-1:0]        i_func,
    input  logic [knn_pkg::POS_W-1:0]         i_feature_pos,
    input  logic signed [knn_pkg::VAL_W-1:0]  i_feature_value,
    input  logic [knn_pkg::SIDX_W-1:0]        i_sample_index,
    input  logic                              i_last_feature,
    // Result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [knn_pkg::RANK_W-1:0]        o_rank,
    output logic [knn_pkg::SIDX_W-1:0]        o_neighbor_index,
    output logic [knn_pkg::DIST_W-1:0]        o_neighbor_distance_sq,
    output logic                              o_last,
    // Configuration
    input  logic                              i_cfg_we,
    input  logic [knn_pkg::DIST_W-1:0]        i_cfg_data
);

    // The readout sequencer has three phases. In normal running every transaction
    // is taken. A readout transaction first waits until no training feature or
    // insertion candidate is still traveling, so the list is final, and then
    // sends the slots out through the output register one per transaction.
    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_DRAIN = 3'b010,
        ST_EMIT  = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic [knn_pkg::SLOT_W-1:0]    r_cnt, n_cnt;
    logic [knn_pkg::DIST_W-1:0]    r_limit;

    logic                          r_o_valid, n_o_valid;
    logic [knn_pkg::RANK_W-1:0]    r_o_rank;
    knn_pkg::t_slot                r_o_slot;
    logic                          r_o_last;

    logic                          w_accept;
    logic                          w_dist_busy;
    logic                          w_chain_busy;
    logic                          w_load;
    logic                          w_clear;

    knn_pkg::t_cand                w_cand [knn_pkg::NEIGHBORS + 1];
    knn_pkg::t_slot                w_slot [knn_pkg::NEIGHBORS];
    logic [knn_pkg::NEIGHBORS-1:0] w_cand_v;

    assign o_ready  = (r_state == ST_RUN);
    assign w_accept = i_valid && o_ready;

    // The limit register only takes effect at the next list clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= knn_pkg::DIST_MAX;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    knn_dist u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_func   (i_func),
        .i_pos    (i_feature_pos),
        .i_val    (i_feature_value),
        .i_idx    (i_sample_index),
        .i_last   (i_last_feature),
        .i_clear  (w_clear),
        .o_cand   (w_cand[0]),
        .o_busy   (w_dist_busy)
    );

    // A new candidate enters cell 0 and walks down the chain one cell per cycle.
    // Each cell keeps the nearer of its slot and the candidate and passes the other
    // on, which shifts the tail down by one; whatever leaves the last cell is dropped.
    for (genvar g = 0; g < knn_pkg::NEIGHBORS; g++) begin : g_cell
        knn_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (w_clear),
            .i_limit (r_limit),
            .i_cand  (w_cand[g]),
            .o_cand  (w_cand[g+1]),
            .o_slot  (w_slot[g])
        );
        assign w_cand_v[g] = w_cand[g+1].valid;
    end

    assign w_chain_busy = |w_cand_v;

    // In the emit phase, the output register is loaded whenever it is empty or being taken.
    assign w_load  = (r_state == ST_EMIT) && (!r_o_valid || i_ready);
    assign w_clear = w_load && (r_cnt == knn_pkg::SLOT_LAST);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_o_valid = r_o_valid;
        if (i_ready) begin
            n_o_valid = 1'b0;
        end
        case (r_state)
            ST_RUN: begin
                if (w_accept && i_func == knn_pkg::FUNC_READ) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!w_dist_busy && !w_chain_busy) begin
                    n_state = ST_EMIT;
                    n_cnt   = '0;
                end
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_o_valid = 1'b1;
                    n_cnt     = r_cnt + 1'b1;
                    if (w_clear) begin
                        n_state = ST_RUN;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RUN;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_rank <= knn_pkg::RANK_W'(r_cnt);
            r_o_slot <= w_slot[r_cnt];
            r_o_last <= (r_cnt == knn_pkg::SLOT_LAST);
        end
    end

    assign o_valid                = r_o_valid;
    assign o_rank                 = r_o_rank;
    assign o_neighbor_index       = r_o_slot.idx;
    assign o_neighbor_distance_sq = r_o_slot.dist_sq;
    assign o_last                 = r_o_last;

    // The slots are sent only once no insertion is still moving through the chain.
    a_emit_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (!w_chain_busy && !w_dist_busy))
        else $error("readout started while an insertion was in flight");

    // The final slot of a readout carries the highest rank.
    a_last_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_rank == knn_pkg::RANK_W'(knn_pkg::NEIGHBORS - 1)))
        else $error("last flag on a slot other than the final one");

    // Clearing the list refills the nearest slot with the limit in force.
    a_clear_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> (w_slot[0].dist_sq == $past(r_limit) && w_slot[0].idx == '0))
        else $error("list clear did not refill the first slot");

endmodule

[src/knn_dist.sv]
// Distance pipeline: query feature memory, difference, square and saturating sum.
// Emits one insertion candidate per finished training vector. Uses knn_pkg.
module knn_dist (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [knn_pkg::FUNC_W-1:0]    i_func,
    input  logic [knn_pkg::POS_W-1:0]     i_pos,
    input  logic signed [knn_pkg::VAL_W-1:0] i_val,
    input  logic [knn_pkg::SIDX_W-1:0]    i_idx,
    input  logic                          i_last,
    input  logic                          i_clear,
    output knn_pkg::t_cand                o_cand,
    output logic                          o_busy
);

    logic [knn_pkg::VAL_W-1:0] r_mem [knn_pkg::FEATURES];

    logic                          w_in_range;
    logic [knn_pkg::QADDR_W-1:0]   w_addr;

    // Stage A: query read
    logic                          r_a_v, r_a_in_range, r_a_last;
    logic [knn_pkg::VAL_W-1:0]     r_q, r_a_val;
    logic [knn_pkg::SIDX_W-1:0]    r_a_idx;
    // Stage B: absolute difference
    logic                          r_b_v, r_b_last;
    logic [knn_pkg::ABS_W-1:0]     r_b_abs;
    logic [knn_pkg::SIDX_W-1:0]    r_b_idx;
    // Stage C: square
    logic                          r_c_v, r_c_last;
    logic [knn_pkg::SQ_W-1:0]      r_c_sq;
    logic [knn_pkg::SIDX_W-1:0]    r_c_idx;
    // Stage D: accumulate
    logic [knn_pkg::DIST_W-1:0]    r_acc;
    knn_pkg::t_cand                r_cand;

    logic [knn_pkg::VAL_W-1:0]     w_q;
    logic signed [knn_pkg::VAL_W:0] w_diff;
    logic [knn_pkg::VAL_W:0]       w_abs;
    logic [knn_pkg::DIST_W:0]      w_sum;
    logic [knn_pkg::DIST_W-1:0]    w_sat;

    assign w_in_range = ({1'b0, i_pos} < knn_pkg::FEAT_CNT);
    assign w_addr     = i_pos[knn_pkg::QADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_accept && i_func == knn_pkg::FUNC_LOAD && w_in_range) begin
            r_mem[w_addr] <= i_val;
        end
        r_q <= r_mem[w_addr];
    end

    assign w_q    = r_a_in_range ? r_q : '0;
    assign w_diff = $signed({w_q[knn_pkg::VAL_W-1], w_q})
                  - $signed({r_a_val[knn_pkg::VAL_W-1], r_a_val});
    assign w_abs  = w_diff[knn_pkg::VAL_W] ? (knn_pkg::VAL_W + 1)'(-w_diff)
                                          : w_diff;

    assign w_sum = {1'b0, r_acc} + (knn_pkg::DIST_W + 1)'(r_c_sq);
    assign w_sat = w_sum[knn_pkg::DIST_W] ? knn_pkg::DIST_MAX : w_sum[knn_pkg::DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v  <= 1'b0;
            r_b_v  <= 1'b0;
            r_c_v  <= 1'b0;
            r_acc  <= '0;
            r_cand <= '0;
        end else begin
            r_a_v <= i_accept && i_func == knn_pkg::FUNC_TRAIN;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_cand.valid <= 1'b0;
            if (i_clear) begin
                r_acc <= '0;
            end else if (r_c_v) begin
                if (r_c_last) begin
                    r_cand.valid   <= 1'b1;
                    r_cand.idx     <= r_c_idx;
                    r_cand.dist_sq <= w_sat;
                    r_acc          <= '0;
                end else begin
                    r_acc <= w_sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_in_range <= w_in_range;
        r_a_val      <= i_val;
        r_a_idx      <= i_idx;
        r_a_last     <= i_last;
        r_b_abs      <= w_abs[knn_pkg::ABS_W-1:0];
        r_b_idx      <= r_a_idx;
        r_b_last     <= r_a_last;
        r_c_sq       <= r_b_abs * r_b_abs;
        r_c_idx      <= r_b_idx;
        r_c_last     <= r_b_last;
    end

    assign o_cand = r_cand;
    assign o_busy = r_a_v || r_b_v || r_c_v || r_cand.valid;

endmodule

[src/knn_cell.sv]
// One slot of the systolic sorted neighbor list.
// Keeps a candidate that is not farther than its slot and passes the loser on. Uses knn_pkg.
module knn_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic [knn_pkg::DIST_W-1:0]  i_limit,
    input  knn_pkg::t_cand              i_cand,
    output knn_pkg::t_cand              o_cand,
    output knn_pkg::t_slot              o_slot
);

    knn_pkg::t_slot r_slot;
    knn_pkg::t_cand r_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.idx     <= '0;
            r_slot.dist_sq <= knn_pkg::DIST_MAX;
            r_cand         <= '0;
        end else if (i_clear) begin
            r_slot.idx     <= '0;
            r_slot.dist_sq <= i_limit;
            r_cand.valid   <= 1'b0;
        end else if (i_cand.valid) begin
            // Ties favor the newcomer, so the newest sample ranks first.
            if (i_cand.dist_sq <= r_slot.dist_sq) begin
                r_slot.idx     <= i_cand.idx;
                r_slot.dist_sq <= i_cand.dist_sq;
                r_cand.valid   <= 1'b1;
                r_cand.idx     <= r_slot.idx;
                r_cand.dist_sq <= r_slot.dist_sq;
            end else begin
                r_cand <= i_cand;
            end
        end else begin
            r_cand.valid <= 1'b0;
        end
    end

    assign o_cand = r_cand;
    assign o_slot = r_slot;

endmodule

[bench/tb_knn_top_k_search.sv]
// Self-checking testbench for knn_top_k_search: queued feature transactions, a bit-true
// predictor of the distance sum and the sorted neighbor list, and an ordered result check.
// Depends on knn_pkg and the knn_top_k_search RTL.
module tb_knn_top_k_search;

    // The fourth function code is not used by the block; it must be ignored.
    localparam logic [knn_pkg::FUNC_W-1:0] FUNC_NOP = 2'd3;

    // Cycles to let the distance stages and the cell chain drain before a limit write or
    // the end of the run, with margin left over.
    localparam int SETTLE_CYCLES = knn_pkg::NEIGHBORS + 24;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // One input transaction. A set hold bit keeps it back until every expected
    // neighbor has been seen on the result channel.
    typedef struct {
        logic [knn_pkg::FUNC_W-1:0]       func;
        logic [knn_pkg::POS_W-1:0]        pos;
        logic signed [knn_pkg::VAL_W-1:0] value;
        logic [knn_pkg::SIDX_W-1:0]       sidx;
        logic                             last;
        bit                               hold;
    } t_feature_txn;

    // One result transaction: a single slot of the neighbor list.
    typedef struct {
        logic [knn_pkg::RANK_W-1:0] rank;
        logic [knn_pkg::SIDX_W-1:0] idx;
        logic [knn_pkg::DIST_W-1:0] dist_sq;
        logic                       last;
    } t_neighbor_txn;

    // Every input of the block starts at a known value.
    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_valid = 1'b0;
    logic                             o_ready;
    logic [knn_pkg::FUNC_W-1:0]       i_func = FUNC_NOP;
    logic [knn_pkg::POS_W-1:0]        i_feature_pos = '0;
    logic signed [knn_pkg::VAL_W-1:0] i_feature_value = '0;
    logic [knn_pkg::SIDX_W-1:0]       i_sample_index = '0;
    logic                             i_last_feature = 1'b0;
    logic                             o_valid;
    logic                             i_ready = 1'b0;
    logic [knn_pkg::RANK_W-1:0]       o_rank;
    logic [knn_pkg::SIDX_W-1:0]       o_neighbor_index;
    logic [knn_pkg::DIST_W-1:0]       o_neighbor_distance_sq;
    logic                             o_last;
    logic                             i_cfg_we = 1'b0;
    logic [knn_pkg::DIST_W-1:0]       i_cfg_data = '0;

    knn_top_k_search uut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_func                 (i_func),
        .i_feature_pos          (i_feature_pos),
        .i_feature_value        (i_feature_value),
        .i_sample_index         (i_sample_index),
        .i_last_feature         (i_last_feature),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_rank                 (o_rank),
        .o_neighbor_index       (o_neighbor_index),
        .o_neighbor_distance_sq (o_neighbor_distance_sq),
        .o_last                 (o_last),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_data             (i_cfg_data)
    );

    // Stimulus and scoreboard storage.
    t_feature_txn  pending_txns[$];
    t_neighbor_txn expected_neighbors[$];
    t_feature_txn  drv_txn;
    t_neighbor_txn seen_neighbor;
    t_idle_mode    idle_mode = IDLE_NONE;
    int            fail_count = 0;
    int            queued_items = 0;

    // Predictor state: a private copy of everything the block remembers.
    logic signed [knn_pkg::VAL_W-1:0] query_copy [knn_pkg::FEATURES];
    logic [knn_pkg::DIST_W-1:0]       dist_sum;
    logic [knn_pkg::SIDX_W-1:0]       slot_idx_copy [knn_pkg::NEIGHBORS];
    logic [knn_pkg::DIST_W-1:0]       slot_dist_copy [knn_pkg::NEIGHBORS];
    logic [knn_pkg::DIST_W-1:0]       limit_copy;

    // Generator shadow of the query, so that training features only ever read
    // query entries that were written before.
    logic signed [knn_pkg::VAL_W-1:0] gen_query [knn_pkg::FEATURES];
    bit                               gen_written [knn_pkg::FEATURES];

    // A free-running clock with a period of 20 time units.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop, far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Empty every slot: index 0 and the limit that is in force right now.
    function automatic void clear_slots();
        for (int s = 0; s < knn_pkg::NEIGHBORS; s++) begin
            slot_idx_copy[s]  = '0;
            slot_dist_copy[s] = limit_copy;
        end
    endfunction

    // Advance the predicted state by one accepted input transaction. A readout
    // queues one expected neighbor per slot, nearest first.
    function automatic void predict_transaction(input t_feature_txn t);
        int                q;
        int                diff;
        longint unsigned   sq;
        longint unsigned   acc;
        bit                placed;
        t_neighbor_txn     nb;
        q = 0;
        placed = 1'b0;
        case (t.func)
            knn_pkg::FUNC_LOAD: begin
                if (t.pos < knn_pkg::FEATURES) begin
                    query_copy[t.pos[knn_pkg::QADDR_W-1:0]] = t.value;
                end
            end
            knn_pkg::FUNC_TRAIN: begin
                // Positions past the query length compare against zero.
                if (t.pos < knn_pkg::FEATURES) begin
                    q = int'(query_copy[t.pos[knn_pkg::QADDR_W-1:0]]);
                end
                diff = q - int'(t.value);
                sq   = longint'(diff) * longint'(diff);
                acc  = dist_sum + sq;
                if (acc > knn_pkg::DIST_MAX) begin
                    acc = knn_pkg::DIST_MAX;
                end
                dist_sum = knn_pkg::DIST_W'(acc);
                if (t.last) begin
                    // The first slot that is not nearer takes the sample, so a tie puts
                    // the newest sample ahead; the tail moves down and the last drops.
                    for (int s = 0; s < knn_pkg::NEIGHBORS; s++) begin
                        if (!placed && dist_sum <= slot_dist_copy[s]) begin
                            for (int m = knn_pkg::NEIGHBORS - 1; m > s; m--) begin
                                slot_idx_copy[m]  = slot_idx_copy[m - 1];
                                slot_dist_copy[m] = slot_dist_copy[m - 1];
                            end
                            slot_idx_copy[s]  = t.sidx;
                            slot_dist_copy[s] = dist_sum;
                            placed = 1'b1;
                        end
                    end
                    dist_sum = '0;
                end
            end
            knn_pkg::FUNC_READ: begin
                for (int s = 0; s < knn_pkg::NEIGHBORS; s++) begin
                    nb.rank    = knn_pkg::RANK_W'(s);
                    nb.idx     = slot_idx_copy[s];
                    nb.dist_sq = slot_dist_copy[s];
                    nb.last    = (s == knn_pkg::NEIGHBORS - 1);
                    expected_neighbors = {expected_neighbors, nb};
                end
                clear_slots();
                dist_sum = '0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic bit sender_idles();
        return (idle_mode == IDLE_SENDER && $urandom_range(99) < 61) ||
               (idle_mode == IDLE_BOTH   && $urandom_range(99) < 12);
    endfunction

    function automatic bit receiver_stalls();
        return (idle_mode == IDLE_RECEIVER && $urandom_range(99) < 61) ||
               (idle_mode == IDLE_BOTH     && $urandom_range(99) < 12);
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Driver. A transaction is accepted at an edge where valid and ready are both
    // high; the predictor sees it at that edge. Valid is only dropped or a new
    // transaction presented when the current one has gone or none is shown.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_transaction(drv_txn);
            end
            if (!i_valid || o_ready) begin
                if (pending_txns.size() != 0 &&
                    !(pending_txns[0].hold && expected_neighbors.size() != 0) &&
                    !sender_idles()) begin
                    drv_txn = pending_txns.pop_front();
                    i_valid         <= 1'b1;
                    i_func          <= drv_txn.func;
                    i_feature_pos   <= drv_txn.pos;
                    i_feature_value <= drv_txn.value;
                    i_sample_index  <= drv_txn.sidx;
                    i_last_feature  <= drv_txn.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Every accepted result transaction is matched against the oldest
    // expected neighbor, field by field; ready is redrawn every cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_neighbors.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual rank %0d index %0d",
                             $time, o_rank, o_neighbor_index);
                    fail_count++;
                end else begin
                    seen_neighbor = expected_neighbors.pop_front();
                    check_field("rank", seen_neighbor.rank, o_rank);
                    check_field("neighbor_index", seen_neighbor.idx, o_neighbor_index);
                    check_field("neighbor_distance_sq", seen_neighbor.dist_sq,
                                o_neighbor_distance_sq);
                    check_field("last", seen_neighbor.last, o_last);
                end
            end
            i_ready <= !receiver_stalls();
        end
    end

    task automatic push_txn(input logic [knn_pkg::FUNC_W-1:0] func,
                            input logic [knn_pkg::POS_W-1:0] pos,
                            input logic signed [knn_pkg::VAL_W-1:0] value,
                            input logic [knn_pkg::SIDX_W-1:0] sidx, input logic last,
                            input bit hold);
        t_feature_txn t;
        t.func  = func;
        t.pos   = pos;
        t.value = value;
        t.sidx  = sidx;
        t.last  = last;
        t.hold  = hold;
        pending_txns = {pending_txns, t};
        if (func != FUNC_NOP) begin
            queued_items++;
        end
        if (func == knn_pkg::FUNC_LOAD && pos < knn_pkg::FEATURES) begin
            gen_query[pos[knn_pkg::QADDR_W-1:0]]   = value;
            gen_written[pos[knn_pkg::QADDR_W-1:0]] = 1'b1;
        end
    endtask

    // Sampled at the falling edge, so the answer does not hinge on the order in
    // which the clocked blocks run at the rising edge.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_txns.size() != 0 || i_valid || expected_neighbors.size() != 0);
    endtask

    // The limit is only written while the block is idle.
    task automatic write_limit(input logic [knn_pkg::DIST_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        limit_copy = value;
    endtask

    // A training position whose query entry is known, or a position past the query length.
    function automatic logic [knn_pkg::POS_W-1:0] pick_train_pos();
        int p;
        p = $urandom_range(knn_pkg::FEATURES - 1);
        if ($urandom_range(9) == 0 || !gen_written[p]) begin
            return knn_pkg::POS_W'($urandom_range(1023, knn_pkg::FEATURES));
        end
        return knn_pkg::POS_W'(p);
    endfunction

    function automatic logic [knn_pkg::SIDX_W-1:0] pick_sidx();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return knn_pkg::SIDX_W'($urandom);
        endcase
    endfunction

    // A whole training vector. An exact vector copies the query, so its distance is
    // zero; the others mix extremes, near misses and random values.
    task automatic add_vector(input bit exact);
        int                               len;
        logic [knn_pkg::POS_W-1:0]        p;
        logic signed [knn_pkg::VAL_W-1:0] v;
        logic [knn_pkg::SIDX_W-1:0]       sid;
        len = ($urandom_range(7) == 0) ? $urandom_range(20, 8) : $urandom_range(4, 1);
        sid = pick_sidx();
        for (int k = 0; k < len; k++) begin
            p = pick_train_pos();
            v = knn_pkg::VAL_W'($urandom);
            if (exact) begin
                v = (p < knn_pkg::FEATURES) ? gen_query[p[knn_pkg::QADDR_W-1:0]] : '0;
            end else begin
                case ($urandom_range(7))
                    0: v = 16'sh7FFF;
                    1: v = 16'sh8000;
                    2, 3: begin
                        if (p < knn_pkg::FEATURES) begin
                            v = gen_query[p[knn_pkg::QADDR_W-1:0]]
                              + knn_pkg::VAL_W'($urandom_range(6)) - 16'sd3;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            push_txn(knn_pkg::FUNC_TRAIN, p, v, sid, k == len - 1, 1'b0);
        end
    endtask

    // Mostly well-formed vectors with the odd readout, plus noise: ignored codes,
    // query rewrites and vectors that never see their last feature.
    task automatic run_random(input int budget);
        int start;
        int r;
        start = queued_items;
        while (queued_items - start < budget) begin
            r = $urandom_range(99);
            if (r < 4) begin
                push_txn(FUNC_NOP, knn_pkg::POS_W'($urandom), knn_pkg::VAL_W'($urandom),
                         knn_pkg::SIDX_W'($urandom), 1'($urandom), 1'b0);
            end else if (r < 8) begin
                push_txn(knn_pkg::FUNC_LOAD,
                         ($urandom_range(9) == 0)
                             ? knn_pkg::POS_W'($urandom_range(1023, knn_pkg::FEATURES))
                             : knn_pkg::POS_W'($urandom_range(knn_pkg::FEATURES - 1)),
                         knn_pkg::VAL_W'($urandom), knn_pkg::SIDX_W'($urandom),
                         1'($urandom), 1'b0);
            end else if (r < 11) begin
                // A vector cut short: its partial sum runs on into the next one.
                push_txn(knn_pkg::FUNC_TRAIN, pick_train_pos(), knn_pkg::VAL_W'($urandom),
                         pick_sidx(), 1'b0, 1'b0);
            end else if (r < 15) begin
                push_txn(knn_pkg::FUNC_READ, knn_pkg::POS_W'($urandom),
                         knn_pkg::VAL_W'($urandom), knn_pkg::SIDX_W'($urandom),
                         1'($urandom), $urandom_range(3) == 0);
            end else begin
                add_vector($urandom_range(7) == 0);
            end
        end
        push_txn(knn_pkg::FUNC_READ, knn_pkg::POS_W'($urandom), knn_pkg::VAL_W'($urandom),
                 knn_pkg::SIDX_W'($urandom), 1'b0, 1'b0);
    endtask

    // Main sequence: reset, a directed opening, then random phases under
    // different limits and idling patterns, and the final verdict.
    initial begin
        dist_sum   = '0;
        limit_copy = knn_pkg::DIST_MAX;
        clear_slots();
        for (int p = 0; p < knn_pkg::FEATURES; p++) begin
            gen_written[p] = 1'b0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening. A readout right after reset shows an empty list.
        push_txn(knn_pkg::FUNC_READ, '0, '0, '0, 1'b0, 1'b0);
        // Query extremes; a last marker on a load is ignored, and loads past the
        // query length are dropped.
        push_txn(knn_pkg::FUNC_LOAD, 10'd0, 16'sh7FFF, 16'hFFFF, 1'b1, 1'b0);
        push_txn(knn_pkg::FUNC_LOAD, 10'd1, 16'sh8000, 16'h0000, 1'b0, 1'b0);
        push_txn(knn_pkg::FUNC_LOAD, 10'd2, 16'sh0000, 16'h0000, 1'b0, 1'b0);
        push_txn(knn_pkg::FUNC_LOAD, knn_pkg::POS_W'(knn_pkg::FEATURES - 1), 16'sh0001,
                 16'h0000, 1'b0, 1'b0);
        push_txn(knn_pkg::FUNC_LOAD, knn_pkg::POS_W'(knn_pkg::FEATURES), 16'sh022B,
                 16'h0000, 1'b0, 1'b0);
        push_txn(knn_pkg::FUNC_LOAD, 10'h3FF, 16'shFFFF, 16'h0000, 1'b0, 1'b0);
        // The unused function code, with every other field at all ones.
        push_txn(FUNC_NOP, 10'h3FF, 16'shFFFF, 16'hFFFF, 1'b1, 1'b0);
        // Largest difference on two features.
        push_txn(knn_pkg::FUNC_TRAIN, 10'd0, 16'sh8000, 16'hFFFF, 1'b0, 1'b0);
        push_txn(knn_pkg::FUNC_TRAIN, 10'd1, 16'sh7FFF, 16'hFFFF, 1'b1, 1'b0);
        // A position past the query length compares against zero.
        push_txn(knn_pkg::FUNC_TRAIN, 10'h3FF, 16'sh8000, 16'h1234, 1'b1, 1'b0);
        // Two samples at the same distance: the newer one must rank first.
        push_txn(knn_pkg::FUNC_TRAIN, 10'd2, 16'sh0003, 16'h0005, 1'b1, 1'b0);
        push_txn(knn_pkg::FUNC_TRAIN, 10'd2, -16'sh0003, 16'h0006, 1'b1, 1'b0);
        // Zero distance, once with sample index zero.
        push_txn(knn_pkg::FUNC_TRAIN, 10'd2, 16'sh0000, 16'h0000, 1'b1, 1'b0);
        push_txn(knn_pkg::FUNC_TRAIN, knn_pkg::POS_W'(knn_pkg::FEATURES - 1), 16'sh0001,
                 16'hAAAA, 1'b1, 1'b0);
        push_txn(knn_pkg::FUNC_READ, '0, '0, '0, 1'b0, 1'b0);
        // The sender holds this one back until the whole readout has arrived.
        push_txn(knn_pkg::FUNC_TRAIN, 10'd0, 16'sh7FFF, 16'h5555, 1'b1, 1'b1);
        push_txn(knn_pkg::FUNC_READ, '0, '0, '0, 1'b0, 1'b0);

        // Full limit, no idling; the whole query is loaded first.
        write_limit(knn_pkg::DIST_MAX);
        idle_mode = IDLE_NONE;
        for (int p = 0; p < knn_pkg::FEATURES; p++) begin
            push_txn(knn_pkg::FUNC_LOAD, knn_pkg::POS_W'(p), knn_pkg::VAL_W'($urandom),
                     knn_pkg::SIDX_W'($urandom), 1'($urandom), 1'b0);
        end
        run_random(50);

        // A zero limit keeps only exact matches once the next readout has cleared the list.
        write_limit('0);
        idle_mode = IDLE_SENDER;
        run_random(45);

        write_limit(knn_pkg::DIST_W'($urandom_range(1 << 18)));
        idle_mode = IDLE_RECEIVER;
        run_random(45);

        write_limit(knn_pkg::DIST_W'({$urandom, $urandom}) >> 8);
        idle_mode = IDLE_BOTH;
        run_random(45);

        write_limit(knn_pkg::DIST_W'({$urandom, $urandom}));
        idle_mode = IDLE_SENDER;
        run_random(45);

        // Full limit again with both sides idling now and then.
        write_limit(knn_pkg::DIST_MAX);
        idle_mode = IDLE_BOTH;
        run_random(40);

        write_limit(knn_pkg::DIST_W'(1));
        idle_mode = IDLE_RECEIVER;
        run_random(40);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[knn_top_k_search.f]
src/knn_pkg.sv
src/knn_dist.sv
src/knn_cell.sv
src/knn_top_k_search.sv
bench/tb_knn_top_k_search.sv
